### rtl/core/sslcd_pkg.sv
package sslcd_pkg;

	// Request codes
	localparam logic [1:0] OP_DISPLAY = 2'd0;
	localparam logic [1:0] OP_FILL    = 2'd1;
	localparam logic [1:0] OP_COMMAND = 2'd2;

	// Frame mode fields
	localparam logic [2:0] MODE_CMD   = 3'h4;
	localparam logic [2:0] MODE_WRITE = 3'h5;

	// Field widths
	localparam int NUMBER_W = 20;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 6;
	localparam int FRAME_W  = 17;
	localparam int FLEN_W   = 5;
	localparam int IDX_W    = 3;

	localparam logic [FLEN_W-1:0] FLEN_WRITE = 5'd17;
	localparam logic [FLEN_W-1:0] FLEN_CMD   = 5'd11;

	localparam logic [NUMBER_W-1:0] NUMBER_MAX = 20'd999999;

	// Reciprocal of ten: n / 10 == (n * DIV10_MUL) >> DIV10_SHIFT for 20-bit n
	localparam logic [NUMBER_W-1:0] DIV10_MUL   = 20'd838861;
	localparam int                  DIV10_SHIFT = 23;

	localparam int DIGIT_COUNT_DEF = 6;

	// One frame as handed from the sequencer to the output stage
	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_desc_t;

	// Seven-segment pattern for one decimal digit
	function automatic logic [BYTE_W-1:0] seg_lookup(input logic [3:0] digit);
		logic [BYTE_W-1:0] seg;
		unique case (digit)
			4'd0: seg = 8'h7D;
			4'd1: seg = 8'h60;
			4'd2: seg = 8'h3E;
			4'd3: seg = 8'h7A;
			4'd4: seg = 8'h63;
			4'd5: seg = 8'h5B;
			4'd6: seg = 8'h5F;
			4'd7: seg = 8'h70;
			4'd8: seg = 8'h7F;
			4'd9: seg = 8'h7B;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

### rtl/core/sslcd_req_if.sv
interface sslcd_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        op;
	logic [sslcd_pkg::NUMBER_W-1:0]    number;
	logic [1:0]                        dot_position;
	logic [1:0]                        battery_level;
	logic [sslcd_pkg::BYTE_W-1:0]      byte_value;

	modport source (
		output valid, op, number, dot_position, battery_level, byte_value,
		input  ready
	);
	modport sink (
		input  valid, op, number, dot_position, battery_level, byte_value,
		output ready
	);
endinterface

### rtl/core/sslcd_frm_if.sv
interface sslcd_frm_if;
	logic                              valid;
	logic                              ready;
	logic                              is_write;
	logic [sslcd_pkg::ADDR_W-1:0]      nibble_address;
	logic [sslcd_pkg::BYTE_W-1:0]      data_byte;
	logic [sslcd_pkg::FRAME_W-1:0]     frame_bits;
	logic [sslcd_pkg::FLEN_W-1:0]      frame_length;
	logic                              last;

	modport source (
		output valid, is_write, nibble_address, data_byte, frame_bits, frame_length, last,
		input  ready
	);
	modport sink (
		input  valid, is_write, nibble_address, data_byte, frame_bits, frame_length, last,
		output ready
	);
endinterface

### rtl/core/seven_segment_lcd_frame_encoder_unit.sv
// The first frame of a request is registered in the sequencer, then in the result register.
// One frame per cycle while frame.ready stays high; a display or fill request gives
// DIGIT_COUNT frames, a command request a single frame, on the single frame output channel.
// Digits are extracted one per cycle, when the output is not stalled, by a reciprocal multiply on the held number.
// Reset (arst_n low) empties the sequencer and result register; no other state.
module seven_segment_lcd_frame_encoder_unit #(
	parameter int DIGIT_COUNT = sslcd_pkg::DIGIT_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sslcd_req_if.sink    req,
	sslcd_frm_if.source  frame
);

	logic                   desc_valid;
	logic                   desc_ready;
	sslcd_pkg::frame_desc_t desc;

	sslcd_seq #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc)
	);

	sslcd_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.frm        (frame)
	);

endmodule

### rtl/core/sslcd_seq.sv
module sslcd_seq #(
	parameter int DIGIT_COUNT = sslcd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sslcd_req_if.sink              req,
	output logic                   desc_valid,
	input  logic                   desc_ready,
	output sslcd_pkg::frame_desc_t desc
);

	localparam logic [sslcd_pkg::IDX_W-1:0] LAST_IDX = sslcd_pkg::IDX_W'(DIGIT_COUNT - 1);

	logic                                busy_q;
	logic [1:0]                          op_q;
	logic [sslcd_pkg::IDX_W-1:0]         idx_q;
	logic [sslcd_pkg::NUMBER_W-1:0]      num_q;
	logic [1:0]                          dot_q;
	logic [1:0]                          bat_q;
	logic [sslcd_pkg::BYTE_W-1:0]        byte_q;

	logic                                is_last;
	logic                                advance;
	logic                                accept;
	logic [2*sslcd_pkg::NUMBER_W-1:0]    prod;
	logic [sslcd_pkg::NUMBER_W-1:0]      quot;
	logic [sslcd_pkg::NUMBER_W-1:0]      quot_x10;
	logic [sslcd_pkg::NUMBER_W-1:0]      diff;
	logic [3:0]                          digit;
	logic                                dot_bit;
	logic                                bat_bit;
	logic [sslcd_pkg::BYTE_W-1:0]        disp_byte;

	// Final frame of the held request
	assign is_last = (op_q == sslcd_pkg::OP_COMMAND) || (idx_q == LAST_IDX);
	assign advance = busy_q && desc_ready;
	assign req.ready = !busy_q || (desc_ready && is_last);
	assign accept = req.valid && req.ready;

	// Peel off the lowest decimal digit
	assign prod     = num_q * sslcd_pkg::DIV10_MUL;
	assign quot     = sslcd_pkg::NUMBER_W'(prod[2*sslcd_pkg::NUMBER_W-1:sslcd_pkg::DIV10_SHIFT]);
	assign quot_x10 = {quot[sslcd_pkg::NUMBER_W-4:0], 3'b000} + {quot[sslcd_pkg::NUMBER_W-2:0], 1'b0};
	assign diff     = num_q - quot_x10;
	assign digit    = diff[3:0];

	// Decimal dot and battery bar flags for this digit position
	assign dot_bit = (dot_q != 2'd0) && ({1'b0, dot_q} == idx_q + 3'd1);
	assign bat_bit = (idx_q >= 3'd3) && (({1'b0, bat_q} + 3'd3) > idx_q);
	assign disp_byte = sslcd_pkg::seg_lookup(digit) | {(dot_bit | bat_bit), 7'b0};

	// Build the descriptor of the current frame
	always_comb begin
		desc_valid = busy_q;
		desc.idx   = idx_q;
		desc.last  = is_last;
		unique case (op_q)
			sslcd_pkg::OP_DISPLAY: begin
				desc.wr   = 1'b1;
				desc.data = disp_byte;
			end
			sslcd_pkg::OP_FILL: begin
				desc.wr   = 1'b1;
				desc.data = byte_q;
			end
			default: begin
				desc.wr   = 1'b0;
				desc.data = byte_q;
			end
		endcase
	end

	// Track whether a request is in progress; drop undefined requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= (req.op == sslcd_pkg::OP_DISPLAY) || (req.op == sslcd_pkg::OP_FILL) ||
				(req.op == sslcd_pkg::OP_COMMAND);
		end else if (advance && is_last) begin
			busy_q <= 1'b0;
		end
	end

	// Load a new request or step to the next digit
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			idx_q  <= '0;
			num_q  <= (req.number > sslcd_pkg::NUMBER_MAX) ? sslcd_pkg::NUMBER_MAX : req.number;
			dot_q  <= req.dot_position;
			bat_q  <= req.battery_level;
			byte_q <= req.byte_value;
		end else if (advance) begin
			idx_q <= idx_q + 3'd1;
			num_q <= quot;
		end
	end

endmodule

### rtl/core/sslcd_out.sv
module sslcd_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   desc_valid,
	output logic                   desc_ready,
	input  sslcd_pkg::frame_desc_t desc,
	sslcd_frm_if.source            frm
);

	logic                              valid_q;
	logic                              wr_q;
	logic [sslcd_pkg::ADDR_W-1:0]      addr_q;
	logic [sslcd_pkg::BYTE_W-1:0]      data_q;
	logic [sslcd_pkg::FRAME_W-1:0]     bits_q;
	logic [sslcd_pkg::FLEN_W-1:0]      len_q;
	logic                              last_q;

	logic                              load;
	logic [sslcd_pkg::ADDR_W-1:0]      nib_addr;

	assign desc_ready = !valid_q || frm.ready;
	assign load       = desc_valid && desc_ready;
	assign nib_addr   = {2'b00, desc.idx, 1'b0};

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (desc_ready) begin
			valid_q <= desc_valid;
		end
	end

	// Format the frame into the result register
	always_ff @(posedge clk) begin
		if (load) begin
			wr_q   <= desc.wr;
			data_q <= desc.data;
			last_q <= desc.last;
			if (desc.wr) begin
				addr_q <= nib_addr;
				bits_q <= {sslcd_pkg::MODE_WRITE, nib_addr, desc.data};
				len_q  <= sslcd_pkg::FLEN_WRITE;
			end else begin
				addr_q <= '0;
				bits_q <= {6'b0, sslcd_pkg::MODE_CMD, desc.data};
				len_q  <= sslcd_pkg::FLEN_CMD;
			end
		end
	end

	assign frm.valid          = valid_q;
	assign frm.is_write       = wr_q;
	assign frm.nibble_address = addr_q;
	assign frm.data_byte      = data_q;
	assign frm.frame_bits     = bits_q;
	assign frm.frame_length   = len_q;
	assign frm.last           = last_q;

endmodule

### verif/seven_segment_lcd_frame_encoder_unit_tb.sv
module seven_segment_lcd_frame_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGITS = sslcd_pkg::DIGIT_COUNT_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	// op code that the encoder must ignore
	localparam logic [1:0] OP_UNDEFINED = 2'd3;

	typedef struct {
		logic [1:0]                     op;
		logic [sslcd_pkg::NUMBER_W-1:0] number;
		logic [1:0]                     dot_position;
		logic [1:0]                     battery_level;
		logic [sslcd_pkg::BYTE_W-1:0]   byte_value;
	} lcd_request_t;

	// one request plus the link behavior in force while it is sent
	typedef struct {
		lcd_request_t req;
		int           snd_idle;
		int           rcv_stall;
		bit           drain_first;
	} request_slot_t;

	typedef struct {
		logic                          is_write;
		logic [sslcd_pkg::ADDR_W-1:0]  nibble_address;
		logic [sslcd_pkg::BYTE_W-1:0]  data_byte;
		logic [sslcd_pkg::FRAME_W-1:0] frame_bits;
		logic [sslcd_pkg::FLEN_W-1:0]  frame_length;
		logic                          last;
	} lcd_frame_t;

	logic clk = 1'b0;
	logic arst_n;

	sslcd_req_if req_ch ();
	sslcd_frm_if frm_ch ();

	seven_segment_lcd_frame_encoder_unit #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.frame(frm_ch)
	);

	request_slot_t pending_reqs[$];
	lcd_frame_t    expected_frames[$];
	request_slot_t offered;
	lcd_frame_t    oldest_frame;
	int            rcv_stall_pct = 0;
	int            fail_count = 0;
	int            cycle_count = 0;

	// link behavior applied to items as they are queued
	int cur_snd_idle = 0;
	int cur_rcv_stall = 0;
	bit next_drain = 1'b0;

	always #5 clk = ~clk;

	// Queue one expected frame
	function automatic void push_frame(logic wr, int idx, logic [sslcd_pkg::BYTE_W-1:0] data,
			logic fin);
		lcd_frame_t f;
		f.is_write = wr;
		f.data_byte = data;
		f.last = fin;
		if (wr) begin
			f.nibble_address = sslcd_pkg::ADDR_W'(idx << 1);
			f.frame_bits = {sslcd_pkg::MODE_WRITE, f.nibble_address, data};
			f.frame_length = sslcd_pkg::FLEN_WRITE;
		end else begin
			f.nibble_address = '0;
			f.frame_bits = {6'd0, sslcd_pkg::MODE_CMD, data};
			f.frame_length = sslcd_pkg::FLEN_CMD;
		end
		expected_frames.push_back(f);
	endfunction

	// Work out the frames that one accepted request must produce
	function automatic void predict_frames(lcd_request_t r);
		logic [sslcd_pkg::BYTE_W-1:0] segs[6];
		int unsigned val;
		case (r.op)
			sslcd_pkg::OP_DISPLAY: begin
				val = (r.number > sslcd_pkg::NUMBER_MAX) ? sslcd_pkg::NUMBER_MAX : r.number;
				for (int i = 0; i < 6; i++) begin
					case (val % 10)
						0: segs[i] = 8'h7D;
						1: segs[i] = 8'h60;
						2: segs[i] = 8'h3E;
						3: segs[i] = 8'h7A;
						4: segs[i] = 8'h63;
						5: segs[i] = 8'h5B;
						6: segs[i] = 8'h5F;
						7: segs[i] = 8'h70;
						8: segs[i] = 8'h7F;
						default: segs[i] = 8'h7B;
					endcase
					val = val / 10;
				end
				if (r.dot_position != 0)
					segs[r.dot_position - 1][7] = 1'b1;
				if (r.battery_level > 0)
					segs[3][7] = 1'b1;
				if (r.battery_level > 1)
					segs[4][7] = 1'b1;
				if (r.battery_level > 2)
					segs[5][7] = 1'b1;
				for (int i = 0; i < DIGITS; i++)
					push_frame(1'b1, i, segs[i], i == DIGITS - 1);
			end
			sslcd_pkg::OP_FILL: begin
				for (int i = 0; i < DIGITS; i++)
					push_frame(1'b1, i, r.byte_value, i == DIGITS - 1);
			end
			sslcd_pkg::OP_COMMAND: begin
				push_frame(1'b0, 0, r.byte_value, 1'b1);
			end
			default: begin
				// undefined op: nothing comes out
			end
		endcase
	endfunction

	function automatic void add_request(logic [1:0] op, logic [sslcd_pkg::NUMBER_W-1:0] number,
			logic [1:0] dot, logic [1:0] bat, logic [sslcd_pkg::BYTE_W-1:0] bval);
		request_slot_t s;
		s.req.op = op;
		s.req.number = number;
		s.req.dot_position = dot;
		s.req.battery_level = bat;
		s.req.byte_value = bval;
		s.snd_idle = cur_snd_idle;
		s.rcv_stall = cur_rcv_stall;
		s.drain_first = next_drain;
		next_drain = 1'b0;
		pending_reqs.push_back(s);
	endfunction

	// Queue random requests until count of them are ones the block acts on
	function automatic void add_random_requests(int count);
		int made;
		int roll;
		logic [1:0] op;
		logic [sslcd_pkg::NUMBER_W-1:0] num;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(99);
			if (roll < 55)
				op = sslcd_pkg::OP_DISPLAY;
			else if (roll < 75)
				op = sslcd_pkg::OP_FILL;
			else if (roll < 95)
				op = sslcd_pkg::OP_COMMAND;
			else
				op = OP_UNDEFINED;
			roll = $urandom_range(99);
			if (roll < 60)
				num = sslcd_pkg::NUMBER_W'($urandom_range(999999));
			else if (roll < 80)
				num = sslcd_pkg::NUMBER_W'($urandom_range(20'hFFFFF, 1000000));
			else
				num = sslcd_pkg::NUMBER_W'($urandom_range(99));
			next_drain = next_drain || ($urandom_range(99) < 3);
			add_request(op, num, 2'($urandom_range(3)), 2'($urandom_range(3)),
				8'($urandom_range(255)));
			if (op != OP_UNDEFINED)
				made++;
		end
	endfunction

	function automatic void check_field(string name, logic [sslcd_pkg::FRAME_W-1:0] want,
			logic [sslcd_pkg::FRAME_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Request driver: hold the item until taken, then predict and offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= sslcd_pkg::OP_DISPLAY;
			req_ch.number <= '0;
			req_ch.dot_position <= '0;
			req_ch.battery_level <= '0;
			req_ch.byte_value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_frames(offered.req);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0
						&& !(pending_reqs[0].drain_first && expected_frames.size() != 0)
						&& $urandom_range(99) >= pending_reqs[0].snd_idle) begin
					offered = pending_reqs.pop_front();
					rcv_stall_pct = offered.rcv_stall;
					req_ch.valid <= 1'b1;
					req_ch.op <= offered.req.op;
					req_ch.number <= offered.req.number;
					req_ch.dot_position <= offered.req.dot_position;
					req_ch.battery_level <= offered.req.battery_level;
					req_ch.byte_value <= offered.req.byte_value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor: compare each taken frame with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_ch.ready <= 1'b0;
		end else begin
			if (frm_ch.valid && frm_ch.ready) begin
				if (expected_frames.size() == 0) begin
					$display("%0t: unexpected frame, expected none, actual bits %0h", $time,
						frm_ch.frame_bits);
					fail_count++;
				end else begin
					oldest_frame = expected_frames.pop_front();
					check_field("is_write", oldest_frame.is_write, frm_ch.is_write);
					check_field("nibble_address", oldest_frame.nibble_address,
						frm_ch.nibble_address);
					check_field("data_byte", oldest_frame.data_byte, frm_ch.data_byte);
					check_field("frame_bits", oldest_frame.frame_bits, frm_ch.frame_bits);
					check_field("frame_length", oldest_frame.frame_length, frm_ch.frame_length);
					check_field("last", oldest_frame.last, frm_ch.last);
				end
			end
			frm_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// Directed: digit range, saturation, dots, battery bars, all ops
		add_request(sslcd_pkg::OP_DISPLAY, 20'd0, 2'd0, 2'd0, 8'h00);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd999999, 2'd3, 2'd3, 8'hFF);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd1000000, 2'd0, 2'd0, 8'h00);
		add_request(sslcd_pkg::OP_DISPLAY, 20'hFFFFF, 2'd1, 2'd1, 8'h00);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd123456, 2'd1, 2'd2, 8'h00);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd789012, 2'd2, 2'd3, 8'h00);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd345678, 2'd3, 2'd0, 8'h00);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd900, 2'd0, 2'd3, 8'h00);
		next_drain = 1'b1;
		add_request(sslcd_pkg::OP_FILL, 20'd0, 2'd0, 2'd0, 8'h00);
		add_request(sslcd_pkg::OP_FILL, 20'hFFFFF, 2'd3, 2'd3, 8'hFF);
		add_request(sslcd_pkg::OP_FILL, 20'd0, 2'd0, 2'd0, 8'hA5);
		add_request(sslcd_pkg::OP_COMMAND, 20'd0, 2'd0, 2'd0, 8'h00);
		add_request(sslcd_pkg::OP_COMMAND, 20'hFFFFF, 2'd3, 2'd3, 8'hFF);
		add_request(OP_UNDEFINED, 20'd123456, 2'd2, 2'd2, 8'h5A);
		add_request(sslcd_pkg::OP_COMMAND, 20'd0, 2'd0, 2'd0, 8'h5A);
		add_request(sslcd_pkg::OP_DISPLAY, 20'd5, 2'd1, 2'd0, 8'h00);

		// Random phases: free flow, sender gaps, receiver stalls, both
		next_drain = 1'b1;
		add_random_requests(21);
		cur_snd_idle = 69;
		next_drain = 1'b1;
		add_random_requests(21);
		cur_snd_idle = 0;
		cur_rcv_stall = 69;
		next_drain = 1'b1;
		add_random_requests(21);
		cur_snd_idle = 20;
		cur_rcv_stall = 20;
		next_drain = 1'b1;
		add_random_requests(21);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain everything, then let the pipeline settle
		while (pending_reqs.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
